// ===== sv/crcot_pkg.sv =====
// Shared types, codes and the CRC byte step for the CRC-keyed ordered table.
package crcot_pkg;

	localparam int unsigned CRCOT_CAPACITY = 16;
	localparam int unsigned CRCOT_QDEPTH   = 2;

	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
	localparam logic [31:0] VALUE_NONE = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_GET    = 3'd2,
		OP_EDIT   = 3'd3,
		OP_COUNT  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// finished key: operation, hash and value, handed from front to back
	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] hash;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] hash;
		logic [31:0] value;
	} entry_t;

	// one reflected CRC-32 byte step, LSB first
	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== sv/crc32_keyed_ordered_table_core.sv =====
// Top level of the CRC-32 keyed table kept in insertion order.
//
//  channel   dir  handshake            fields
//  -------   ---  -------------------  ------------------------------------------
//  input     in   push / full          opcode, key_byte, key_last, entry_value
//  result    out  empty / pop          status, found_value, match_count, occupied
//
// A key byte transfers when push is high and full is low; the CRC is folded in the
// front end as it arrives. The last byte queues a command; the engine takes it once
// idle and the result register is free. Add, unknown opcodes and lookups on an empty
// table finish straight from idle; get/edit/count/remove otherwise read and compare
// each entry examined, and remove then reads and writes each entry it shifts down.
// Reset is asynchronous: CRC to all ones, table empty; the memory itself is not cleared.
// full stalls only when the command queue is full; a result waits until popped.
module crc32_keyed_ordered_table_core
	import crcot_pkg::*;
#(
	parameter int unsigned CAPACITY    = CRCOT_CAPACITY,
	parameter int unsigned QUEUE_DEPTH = CRCOT_QDEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         opcode,
	input  logic [7:0]         key_byte,
	input  logic               key_last,
	input  logic signed [31:0] entry_value,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic signed [31:0] found_value,
	output logic [4:0]         match_count,
	output logic [4:0]         occupied
);

	logic        take;
	logic        cmd_push;
	cmd_t        cmd;
	logic        q_empty;
	logic        q_pop;
	cmd_t        q_data;
	logic [31:0] found_raw;

	// a byte transfers whenever the queue has room
	assign take = push & ~full;

	crcot_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.opcode      (opcode),
		.key_byte    (key_byte),
		.key_last    (key_last),
		.entry_value (entry_value),
		.cmd_push    (cmd_push),
		.cmd         (cmd)
	);

	crcot_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd),
		.full   (full),
		.pop    (q_pop),
		.empty  (q_empty),
		.dout   (q_data)
	);

	crcot_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.res_empty   (empty),
		.res_pop     (pop),
		.status      (status),
		.found_value (found_raw),
		.match_count (match_count),
		.occupied    (occupied)
	);

	assign found_value = found_raw;

endmodule

// ===== sv/crcot_front.sv =====
// Front end: folds key bytes into the running CRC and emits a command on the last byte.
module crcot_front
	import crcot_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [2:0]  opcode,
	input  logic [7:0]  key_byte,
	input  logic        key_last,
	input  logic [31:0] entry_value,
	output logic        cmd_push,
	output cmd_t        cmd
);

	logic [31:0] crc_q;
	logic [31:0] crc_next;

	// a zero byte leaves the CRC alone
	assign crc_next = (key_byte != 8'd0) ? crc_fold(crc_q, key_byte) : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (take) begin
			crc_q <= key_last ? CRC_INIT : crc_next;
		end
	end

	assign cmd_push   = take & key_last;
	assign cmd.opcode = opcode;
	assign cmd.hash   = ~crc_next;
	assign cmd.value  = entry_value;

endmodule

// ===== sv/crcot_fifo.sv =====
// Small command queue between the hashing front end and the table engine.
module crcot_fifo
	import crcot_pkg::*;
#(
	parameter int unsigned DEPTH = CRCOT_QDEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t dout
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          buf_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/crcot_back.sv =====
// Table engine: ordered hash/value memory, sequential scan, compaction and result register.
module crcot_back
	import crcot_pkg::*;
#(
	parameter int unsigned CAPACITY = CRCOT_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  cmd_t        q_data,
	output logic        q_pop,
	output logic        res_empty,
	input  logic        res_pop,
	output logic [1:0]  status,
	output logic [31:0] found_value,
	output logic [4:0]  match_count,
	output logic [4:0]  occupied
);

	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_RD    = 5'b00010,
		S_CMP   = 5'b00100,
		S_SH_RD = 5'b01000,
		S_SH_WR = 5'b10000
	} state_t;

	state_t        state_q, state_d;
	logic [IW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [CW-1:0] cnt_q, cnt_d;
	cmd_t          cmd_q, cmd_d;

	entry_t        tbl_mem_q [CAPACITY];
	entry_t        rd_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;

	logic          res_vld_q;
	status_t       res_status_q, res_status_d;
	logic [31:0]   res_found_q, res_found_d;
	logic [CW-1:0] res_cnt_q, res_cnt_d;
	logic [CW-1:0] res_occ_q;
	logic          res_set;

	logic [CW-1:0] ptr_ext;
	logic [CW-1:0] ptr_nx;
	logic [CW-1:0] ptr_nx2;
	logic          at_last;
	logic          hit;
	logic [CW-1:0] cnt_cur;
	logic [CW+4:0] cnt_wide;
	logic [CW+4:0] occ_wide;

	assign ptr_ext = CW'(ptr_q);
	assign ptr_nx  = ptr_ext + 1'b1;
	assign ptr_nx2 = ptr_ext + CW'(2);
	assign at_last = (ptr_nx == fill_q);
	assign hit     = (rd_q.hash == cmd_q.hash);
	assign cnt_cur = cnt_q + CW'(hit);

	always_comb begin
		state_d      = state_q;
		ptr_d        = ptr_q;
		fill_d       = fill_q;
		cnt_d        = cnt_q;
		cmd_d        = cmd_q;
		q_pop        = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = ptr_q;
		wr_en        = 1'b0;
		wr_addr      = ptr_q;
		wr_data      = rd_q;
		res_set      = 1'b0;
		res_status_d = ST_DONE;
		res_found_d  = '0;
		res_cnt_d    = '0;
		case (state_q)
			S_IDLE: begin
				if (!q_empty && !res_vld_q) begin
					q_pop = 1'b1;
					cmd_d = q_data;
					ptr_d = '0;
					cnt_d = '0;
					case (q_data.opcode)
						OP_ADD: begin
							res_set = 1'b1;
							if (fill_q == CW'(CAPACITY)) begin
								res_status_d = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = fill_q[IW-1:0];
								wr_data = '{hash: q_data.hash, value: q_data.value};
								fill_d  = fill_q + 1'b1;
							end
						end
						OP_REMOVE, OP_GET, OP_EDIT, OP_COUNT: begin
							if (fill_q == '0) begin
								res_set = 1'b1;
								if (q_data.opcode != OP_COUNT) begin
									res_status_d = ST_MISS;
								end
								if (q_data.opcode == OP_GET) begin
									res_found_d = VALUE_NONE;
								end
							end else begin
								state_d = S_RD;
							end
						end
						default: res_set = 1'b1;
					endcase
				end
			end
			S_RD: begin
				rd_en   = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_IDLE;
				case (cmd_q.opcode)
					OP_COUNT: begin
						if (at_last) begin
							res_set   = 1'b1;
							res_cnt_d = cnt_cur;
						end else begin
							cnt_d   = cnt_cur;
							ptr_d   = ptr_q + 1'b1;
							state_d = S_RD;
						end
					end
					OP_GET: begin
						if (hit) begin
							res_set     = 1'b1;
							res_found_d = rd_q.value;
						end else if (at_last) begin
							res_set      = 1'b1;
							res_status_d = ST_MISS;
							res_found_d  = VALUE_NONE;
						end else begin
							ptr_d   = ptr_q + 1'b1;
							state_d = S_RD;
						end
					end
					OP_EDIT: begin
						if (hit) begin
							res_set = 1'b1;
							wr_en   = 1'b1;
							wr_data = '{hash: rd_q.hash, value: cmd_q.value};
						end else if (at_last) begin
							res_set      = 1'b1;
							res_status_d = ST_MISS;
						end else begin
							ptr_d   = ptr_q + 1'b1;
							state_d = S_RD;
						end
					end
					OP_REMOVE: begin
						if (hit && at_last) begin
							res_set = 1'b1;
							fill_d  = fill_q - 1'b1;
						end else if (hit) begin
							state_d = S_SH_RD;
						end else if (at_last) begin
							res_set      = 1'b1;
							res_status_d = ST_MISS;
						end else begin
							ptr_d   = ptr_q + 1'b1;
							state_d = S_RD;
						end
					end
					default: res_set = 1'b1;
				endcase
			end
			S_SH_RD: begin
				// pull the next entry down one slot
				rd_en   = 1'b1;
				rd_addr = ptr_nx[IW-1:0];
				state_d = S_SH_WR;
			end
			S_SH_WR: begin
				wr_en = 1'b1;
				ptr_d = ptr_q + 1'b1;
				if (ptr_nx2 == fill_q) begin
					res_set = 1'b1;
					fill_d  = fill_q - 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SH_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= tbl_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (res_set) begin
				res_vld_q <= 1'b1;
			end else if (res_pop) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		cnt_q <= cnt_d;
		cmd_q <= cmd_d;
		if (res_set) begin
			res_status_q <= res_status_d;
			res_found_q  <= res_found_d;
			res_cnt_q    <= res_cnt_d;
			res_occ_q    <= fill_d;
		end
	end

	// counts are reported modulo 32
	assign cnt_wide    = {5'd0, res_cnt_q};
	assign occ_wide    = {5'd0, res_occ_q};
	assign res_empty   = ~res_vld_q;
	assign status      = res_status_q;
	assign found_value = res_found_q;
	assign match_count = cnt_wide[4:0];
	assign occupied    = occ_wide[4:0];

endmodule

// ===== sv/crcot_checker.sv =====
// Port-level checker for the CRC-keyed table, bound to the top level.
module crcot_checker
	import crcot_pkg::*;
#(
	parameter int unsigned CAPACITY = CRCOT_CAPACITY
) (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [31:0] found_value,
	input logic [4:0]  match_count,
	input logic [4:0]  occupied
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW+4:0] CAP_WIDE = (CW + 5)'(CAPACITY);
	localparam logic [4:0]    CAP_LOW  = CAP_WIDE[4:0];

	a_full_at_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_FULL) |-> (occupied == CAP_LOW))
		else $error("full status with table not at capacity");

	a_count_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && match_count != 5'd0) |-> (status == ST_DONE && found_value == 32'd0))
		else $error("nonzero match count with other result fields set");

	a_miss_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_MISS) |-> (match_count == 5'd0))
		else $error("miss reported with nonzero match count");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(found_value) && $stable(status)))
		else $error("waiting result changed before transfer");

endmodule

bind crc32_keyed_ordered_table_core crcot_checker #(
	.CAPACITY (CAPACITY)
) u_crcot_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.status      (status),
	.found_value (found_value),
	.match_count (match_count),
	.occupied    (occupied)
);
